// ===== rtl/core/wsmfe_pkg.sv =====
// Shared types and constants of the LED matrix frame encoder.
`default_nettype none

package wsmfe_pkg;

	// Command codes of an input transaction; code 7 is unused and ignored.
	typedef enum logic [2:0] {
		CMD_SET_COLOR    = 3'd0,
		CMD_SET_ON       = 3'd1,
		CMD_SET_BLINK    = 3'd2,
		CMD_ALL_ON       = 3'd3,
		CMD_BLINK_TICK   = 3'd4,
		CMD_EMIT_LED     = 3'd5,
		CMD_EMIT_TRAILER = 3'd6
	} cmd_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
	localparam logic [1:0] REG_ZERO_HIGH  = 2'd1;
	localparam logic [1:0] REG_ONE_HIGH   = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [6:0] BRIGHTNESS_RESET = 7'd16;
	localparam logic [5:0] ZERO_HIGH_RESET  = 6'd20;
	localparam logic [5:0] ONE_HIGH_RESET   = 6'd40;
	localparam logic [6:0] PERCENT_FULL     = 7'd100;

	// Slot counts of the two emit runs.
	localparam int          BITS_PER_LED  = 24;
	localparam logic [4:0]  SLOTS_LED     = 5'd24;
	localparam logic [4:0]  SLOTS_TRAILER = 5'd2;

	// Width of the internal LED index, wide enough to compare against any depth up to 2047.
	localparam int IDX_W = 11;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_SCALE,
		S_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic clear_wr;
		logic capture_prod;
		logic capture_word;
		logic load_trailer;
		logic load_slot;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_done;
		logic slot_free;
		logic last_slot;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/wsmfe_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none

module wsmfe_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/wsmfe_ctrl.sv =====
// Controller state machine of the LED matrix frame encoder.
`default_nettype none

module wsmfe_ctrl import wsmfe_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] command,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (status.clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (command == CMD_EMIT_LED) begin
						state_d = S_READ;
					end else if (command == CMD_EMIT_TRAILER) begin
						cmd.load_trailer = 1'b1;
						state_d          = S_EMIT;
					end
				end
			end
			S_READ: begin
				cmd.capture_prod = 1'b1;
				state_d          = S_SCALE;
			end
			S_SCALE: begin
				cmd.capture_word = 1'b1;
				state_d          = S_EMIT;
			end
			S_EMIT: begin
				if (status.slot_free) begin
					cmd.load_slot = 1'b1;
					if (status.last_slot) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/wsmfe_datapath.sv =====
// Datapath: color store, LED marks, brightness scaling, slot shifter and output register.
`default_nettype none

module wsmfe_datapath import wsmfe_pkg::*; #(
	parameter int NUM_LEDS = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire ctrl_cmd_t  cmd,
	output dp_status_t      status,
	input  wire logic [2:0] command,
	input  wire logic [5:0] led_index,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	input  wire logic       flag,
	input  wire logic       cfg_write,
	input  wire logic [1:0] cfg_index,
	input  wire logic [6:0] cfg_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [5:0]      high_time,
	output logic            code_bit,
	output logic            last
);

	localparam int ADDR_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	// floor(x / 100) equals (x * 5243) >> 19 for every x up to 255 * 100.
	localparam logic [12:0] DIV100_MUL = 13'd5243;
	localparam int          DIV100_SHIFT = 19;

	logic [6:0] bright_q;
	logic [5:0] zero_ht_q;
	logic [5:0] one_ht_q;

	logic [IDX_W-1:0]  idx_ext;
	logic              idx_ok;
	logic [ADDR_W-1:0] addr;
	logic [ADDR_W-1:0] clr_q;

	logic [NUM_LEDS-1:0] on_q;
	logic [NUM_LEDS-1:0] blink_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [23:0]       mem_wdata;
	logic              mem_re;
	logic [23:0]       mem_rdata;

	logic        en_s1;
	logic [14:0] prod_q [3];
	logic [27:0] quot [3];
	logic [23:0] word_q;
	logic [4:0]  slots_q;

	assign idx_ext = {{(IDX_W - 6){1'b0}}, led_index};
	assign idx_ok  = idx_ext < IDX_W'(NUM_LEDS);
	assign addr    = idx_ext[ADDR_W-1:0];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q  <= BRIGHTNESS_RESET;
			zero_ht_q <= ZERO_HIGH_RESET;
			one_ht_q  <= ONE_HIGH_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_BRIGHTNESS: bright_q <= (cfg_data > PERCENT_FULL) ? PERCENT_FULL : cfg_data;
				REG_ZERO_HIGH:  zero_ht_q <= cfg_data[5:0];
				REG_ONE_HIGH:   one_ht_q  <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Clearing pass over the color store after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_wr && !status.clear_done) begin
			clr_q <= clr_q + ADDR_W'(1);
		end
	end

	assign status.clear_done = clr_q == ADDR_W'(NUM_LEDS - 1);

	assign mem_we    = cmd.clear_wr
		|| (cmd.accept && command == CMD_SET_COLOR && idx_ok);
	assign mem_waddr = cmd.clear_wr ? clr_q : addr;
	assign mem_wdata = cmd.clear_wr ? 24'd0 : {green, red, blue};
	assign mem_re    = cmd.accept && command == CMD_EMIT_LED;

	wsmfe_ram #(
		.WIDTH (24),
		.DEPTH (NUM_LEDS)
	) u_color_ram (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (addr),
		.rd_data (mem_rdata)
	);

	// On and blink marks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q    <= '0;
			blink_q <= '0;
			en_s1   <= 1'b0;
		end else if (cmd.accept) begin
			case (command)
				CMD_SET_ON: begin
					if (idx_ok) begin
						on_q[addr] <= flag;
					end
				end
				CMD_SET_BLINK: begin
					if (idx_ok) begin
						on_q[addr]    <= flag;
						blink_q[addr] <= flag;
					end
				end
				CMD_ALL_ON:     on_q <= '1;
				CMD_BLINK_TICK: on_q <= on_q ^ blink_q;
				CMD_EMIT_LED:   en_s1 <= idx_ok && on_q[addr];
				default: ;
			endcase
		end
	end

	// Brightness scaling: channel times percent, then division by 100.
	always_ff @(posedge clk) begin
		if (cmd.capture_prod) begin
			for (int c = 0; c < 3; c++) begin
				prod_q[c] <= en_s1 ? 15'(mem_rdata[8*c +: 8] * bright_q) : 15'd0;
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			quot[c] = 28'(prod_q[c] * DIV100_MUL);
		end
	end

	// Slot shifter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= '0;
		end else if (cmd.capture_word) begin
			slots_q <= SLOTS_LED;
		end else if (cmd.load_trailer) begin
			slots_q <= SLOTS_TRAILER;
		end else if (cmd.load_slot) begin
			slots_q <= slots_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture_word) begin
			word_q <= {quot[2][DIV100_SHIFT +: 8], quot[1][DIV100_SHIFT +: 8],
				quot[0][DIV100_SHIFT +: 8]};
		end else if (cmd.load_trailer) begin
			word_q <= '0;
		end else if (cmd.load_slot) begin
			word_q <= {word_q[BITS_PER_LED-2:0], 1'b0};
		end
	end

	assign status.last_slot = slots_q == 5'd1;
	assign status.slot_free = !out_valid || out_ready;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_slot) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_slot) begin
			code_bit  <= word_q[BITS_PER_LED-1];
			high_time <= word_q[BITS_PER_LED-1] ? one_ht_q : zero_ht_q;
			last      <= status.last_slot;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ws2812_matrix_frame_encoder.sv =====
// Top level of the LED matrix frame encoder.
// The block keeps a color store of NUM_LEDS 24-bit GRB colors, each with an on mark
// and a blink mark, and turns emit commands into serial bit slots for the LED chain.
// Input transactions use in_valid and in_ready; each carries a command and its fields.
// Color, on, blink, all-on and blink-tick commands give no result.
// An emit LED transaction gives 24 output transactions in G, R, B order, MSB first,
// each scaled by the brightness register; an LED that is off or out of range gives
// 24 zero slots. An emit trailer transaction gives two zero slots. The final slot
// of a run has last set. Each slot carries the PWM high time chosen by its bit.
// The first slot of an LED emit goes through these steps: the color is read at
// acceptance, the brightness product is registered, the divide-by-100 reciprocal
// multiply loads the slot shifter, and the first bit loads the output register.
// A trailer loads its first zero slot into the output register after acceptance.
// One item is worked on at a time; the slot shifter moves one bit per cycle
// whenever the output register is free to take the next slot.
// The next transaction is taken as soon as the last slot sits in the output
// register, while that slot still waits to be taken.
// When out_ready is low the slot in the output register holds and the shifter waits.
// After reset the color store is cleared to black, during which
// in_ready stays low; configuration writes are taken at any time.
`default_nettype none

module ws2812_matrix_frame_encoder import wsmfe_pkg::*; #(
	parameter int NUM_LEDS = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] command,
	input  wire logic [5:0] led_index,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	input  wire logic       flag,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [5:0]      high_time,
	output logic            code_bit,
	output logic            last,
	input  wire logic       cfg_write,
	input  wire logic [1:0] cfg_index,
	input  wire logic [6:0] cfg_data
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// The controller sequences clearing, acceptance, scaling and slot output.
	wsmfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds all storage, the scaling multipliers and the output register.
	wsmfe_datapath #(
		.NUM_LEDS (NUM_LEDS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.command   (command),
		.led_index (led_index),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.flag      (flag),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.high_time (high_time),
		.code_bit  (code_bit),
		.last      (last)
	);

endmodule

`default_nettype wire
